@@ hdl/plfc_pkg.sv @@
package plfc_pkg;

  localparam int POINTS    = 6;
  localparam int CFG_W     = 48;
  localparam int TEMP_W    = 16;
  localparam int DUTY_W    = 8;
  localparam int QW        = 8;
  localparam int NSTG      = QW + 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TEMPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTIES = 2'd1;

  localparam logic [CFG_W-1:0] TEMPS_RESET  = 48'd66186119420697;
  localparam logic [CFG_W-1:0] DUTIES_RESET = 48'd281367012362240;

  typedef struct packed {
    logic [7:0]        offset;
    logic signed [8:0] rise;
    logic [7:0]        width;
    logic [7:0]        base;
  } seg_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  q;
    logic [7:0]  width;
    logic        neg;
    logic [7:0]  base;
  } div_t;

  // points past the end of the register read as zero
  function automatic logic signed [15:0] pt_temp(logic [CFG_W-1:0] r, int idx);
    logic [CFG_W-1:0] sh;
    logic [7:0]       b;
    sh = r >> (8 * idx);
    b  = sh[7:0];
    if (8 * idx >= CFG_W) b = '0;
    return {{8{b[7]}}, b};
  endfunction

  function automatic logic [7:0] pt_duty(logic [CFG_W-1:0] r, int idx);
    logic [CFG_W-1:0] sh;
    logic [7:0]       b;
    sh = r >> (8 * idx);
    b  = sh[7:0];
    if (8 * idx >= CFG_W) b = '0;
    return b;
  endfunction

endpackage

@@ hdl/plfc_seg.sv @@
module plfc_seg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              up_valid_i,
  input  logic                              adv_i,
  input  logic signed [plfc_pkg::TEMP_W-1:0] temperature_i,
  input  logic [plfc_pkg::CFG_W-1:0]        temps_i,
  input  logic [plfc_pkg::CFG_W-1:0]        duties_i,
  output logic                              valid_o,
  output plfc_pkg::seg_t                    seg_o
);
  import plfc_pkg::*;

  logic              valid_q;
  seg_t              seg_d, seg_q;
  logic              found;
  logic signed [15:0] lo_t, hi_t, off_w, wid_w;

  always_comb begin
    found = 1'b0;
    lo_t  = '0;
    hi_t  = '0;
    off_w = '0;
    wid_w = '0;
    // outside every segment: flat value, zero product, unit width
    seg_d.offset = '0;
    seg_d.rise   = '0;
    seg_d.width  = 8'd1;
    seg_d.base   = pt_duty(duties_i, POINTS - 1);
    if (temperature_i < pt_temp(temps_i, 0)) begin
      seg_d.base = pt_duty(duties_i, 0);
    end else begin
      for (int i = 0; i < POINTS - 1; i++) begin
        lo_t = pt_temp(temps_i, i);
        hi_t = pt_temp(temps_i, i + 1);
        if (!found && temperature_i >= lo_t && temperature_i < hi_t) begin
          found        = 1'b1;
          off_w        = temperature_i - lo_t;
          wid_w        = hi_t - lo_t;
          seg_d.offset = off_w[7:0];
          seg_d.width  = wid_w[7:0];
          seg_d.base   = pt_duty(duties_i, i);
          seg_d.rise   = $signed({1'b0, pt_duty(duties_i, i + 1)})
                       - $signed({1'b0, pt_duty(duties_i, i)});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && up_valid_i) seg_q <= seg_d;
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule

@@ hdl/plfc_mul.sv @@
module plfc_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           up_valid_i,
  input  logic           adv_i,
  input  plfc_pkg::seg_t seg_i,
  output logic           valid_o,
  output plfc_pkg::div_t div_o
);
  import plfc_pkg::*;

  logic       valid_q;
  div_t       div_d, div_q;
  logic [8:0] neg_rise;
  logic [7:0] mag;

  always_comb begin
    neg_rise    = 9'(-seg_i.rise);
    mag         = seg_i.rise[8] ? neg_rise[7:0] : seg_i.rise[7:0];
    div_d.rem   = 16'(seg_i.offset) * 16'(mag);
    div_d.q     = '0;
    div_d.width = seg_i.width;
    div_d.neg   = seg_i.rise[8];
    div_d.base  = seg_i.base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && up_valid_i) div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

@@ hdl/plfc_div_cell.sv @@
module plfc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           up_valid_i,
  input  logic           adv_i,
  input  plfc_pkg::div_t div_i,
  output logic           valid_o,
  output plfc_pkg::div_t div_o
);
  import plfc_pkg::*;

  logic       valid_q;
  div_t       div_d, div_q;
  logic [8:0] top_r, top_n;
  logic       ge;
  logic [15:0] rem_n;

  // one quotient bit: compare the top of the remainder, then shift left
  always_comb begin
    top_r       = div_i.rem[15:7];
    ge          = top_r >= {1'b0, div_i.width};
    top_n       = ge ? top_r - {1'b0, div_i.width} : top_r;
    rem_n       = {top_n, div_i.rem[6:0]};
    div_d       = div_i;
    div_d.rem   = {rem_n[14:0], 1'b0};
    div_d.q     = {div_i.q[6:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && up_valid_i) div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

@@ hdl/plfc_out.sv @@
module plfc_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        up_valid_i,
  input  logic                        adv_i,
  input  plfc_pkg::div_t              div_i,
  output logic                        valid_o,
  output logic [plfc_pkg::DUTY_W-1:0] duty_o
);
  import plfc_pkg::*;

  logic              valid_q;
  logic [DUTY_W-1:0] duty_d, duty_q;
  logic signed [9:0] qs, v;

  always_comb begin
    qs = div_i.neg ? -$signed({2'b00, div_i.q}) : $signed({2'b00, div_i.q});
    v  = $signed({2'b00, div_i.base}) + qs;
    if (v[9]) begin
      duty_d = '0;
    end else if (v[8]) begin
      duty_d = '1;
    end else begin
      duty_d = v[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && up_valid_i) duty_q <= duty_d;
  end

  assign valid_o = valid_q;
  assign duty_o  = duty_q;

endmodule

@@ hdl/piecewise_linear_fan_curve.sv @@
// channel  direction  handshake            payload
// in       sink       in_valid_i/in_stall_o  temperature_i (s16)
// out      source     out_valid_o/out_stall_i duty_o (u8)
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (48)
//
// one temperature per cycle while in_stall_o is low; the registered stages in order:
// segment select, multiply, eight divider cells (one quotient bit each), output
// reset empties every stage and loads the default six-point curve
// a stalled output holds; upstream cells keep filling bubbles, and in_stall_o
// rises only once every stage holds a beat
module piecewise_linear_fan_curve (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [plfc_pkg::TEMP_W-1:0]   temperature_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [plfc_pkg::DUTY_W-1:0]          duty_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [plfc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [plfc_pkg::CFG_W-1:0]           cfg_data_i
);
  import plfc_pkg::*;

  logic [CFG_W-1:0] temps_q, duties_q;
  logic [NSTG-1:0]  stg_v, adv;
  seg_t             seg;
  div_t             dv [QW+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temps_q  <= TEMPS_RESET;
      duties_q <= DUTIES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TEMPS:  temps_q  <= cfg_data_i;
        REG_DUTIES: duties_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage takes a beat when it is empty or its own beat moves on
  genvar k;
  generate
    for (k = 0; k < NSTG - 1; k++) begin : g_adv
      assign adv[k] = !stg_v[k] || adv[k+1];
    end
  endgenerate
  assign adv[NSTG-1] = !stg_v[NSTG-1] || !out_stall_i;

  assign in_stall_o = !adv[0];

  plfc_seg u_seg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .up_valid_i    (in_valid_i),
    .adv_i         (adv[0]),
    .temperature_i (temperature_i),
    .temps_i       (temps_q),
    .duties_i      (duties_q),
    .valid_o       (stg_v[0]),
    .seg_o         (seg)
  );

  plfc_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (stg_v[0]),
    .adv_i      (adv[1]),
    .seg_i      (seg),
    .valid_o    (stg_v[1]),
    .div_o      (dv[0])
  );

  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_div
      plfc_div_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .up_valid_i (stg_v[g+1]),
        .adv_i      (adv[g+2]),
        .div_i      (dv[g]),
        .valid_o    (stg_v[g+2]),
        .div_o      (dv[g+1])
      );
    end
  endgenerate

  plfc_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (stg_v[NSTG-2]),
    .adv_i      (adv[NSTG-1]),
    .div_i      (dv[QW]),
    .valid_o    (stg_v[NSTG-1]),
    .duty_o     (duty_o)
  );

  assign out_valid_o = stg_v[NSTG-1];

endmodule

@@ hdl/plfc_chk.sv @@
module plfc_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [plfc_pkg::TEMP_W-1:0]   temperature_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [plfc_pkg::DUTY_W-1:0]          duty_o,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o,
  input logic [plfc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input logic [plfc_pkg::CFG_W-1:0]           cfg_data_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_o))
    else $error("stalled result beat changed");

  // input backs up only behind a stalled output
  a_in_stall: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // a cycle in reset leaves the pipe empty and open
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("pipe not empty after reset");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind piecewise_linear_fan_curve plfc_chk u_chk (.*);

@@ tb/sv/fan_curve_checker.sv @@
module fan_curve_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [plfc_pkg::TEMP_W-1:0] temperature_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [plfc_pkg::DUTY_W-1:0]        duty_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [plfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [plfc_pkg::CFG_W-1:0]         cfg_data_i,
  output int                                 mismatch_count_o,
  output int                                 duty_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import plfc_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [DUTY_W-1:0]        duty;
  } duty_due_t;

  logic [CFG_W-1:0] curve_temps_q;
  logic [CFG_W-1:0] curve_duties_q;
  duty_due_t        duty_due[$];
  duty_due_t        oldest;
  int               mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic int temp_at(logic [CFG_W-1:0] r, int idx);
    logic signed [7:0] b;
    b = (8 * idx >= CFG_W) ? 8'sd0 : r[8*idx +: 8];
    return b;
  endfunction

  function automatic int duty_at(logic [CFG_W-1:0] r, int idx);
    logic [7:0] b;
    b = (8 * idx >= CFG_W) ? 8'd0 : r[8*idx +: 8];
    return b;
  endfunction

  function automatic logic [DUTY_W-1:0] curve_duty(logic signed [TEMP_W-1:0] t,
                                                   logic [CFG_W-1:0] temps,
                                                   logic [CFG_W-1:0] duties);
    int tv;
    int lo_t;
    int hi_t;
    int v;
    int i;
    tv = t;
    if (tv < temp_at(temps, 0)) return DUTY_W'(duty_at(duties, 0));
    for (i = 0; i + 1 < POINTS; i++) begin
      lo_t = temp_at(temps, i);
      hi_t = temp_at(temps, i + 1);
      if (tv >= lo_t && tv < hi_t) begin
        if (hi_t - lo_t <= 0) return DUTY_W'(duty_at(duties, i));
        // int division truncates toward zero
        v = duty_at(duties, i) +
            ((tv - lo_t) * (duty_at(duties, i + 1) - duty_at(duties, i))) / (hi_t - lo_t);
        if (v > 255) return '1;
        if (v < 0) return '0;
        return DUTY_W'(v);
      end
    end
    // no matching segment (at or above the last point, or an unsorted curve) falls through to the last point
    return DUTY_W'(duty_at(duties, POINTS - 1));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] duty mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_temps_q  <= TEMPS_RESET;
      curve_duties_q <= DUTIES_RESET;
      duty_due.delete();
      duty_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_TEMPS) curve_temps_q <= cfg_data_i;
        else if (cfg_index_i == REG_DUTIES) curve_duties_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        duty_due.push_back('{temp: temperature_i,
                             duty: curve_duty(temperature_i, curve_temps_q, curve_duties_q)});
      end
      if (out_valid_i && !out_stall_i) begin
        if (duty_due.size() == 0) begin
          report_mismatch($sformatf("duty %0d with no temperature outstanding", duty_i));
        end else begin
          oldest = duty_due.pop_front();
          if (duty_i !== oldest.duty)
            report_mismatch($sformatf("temp %0d gave duty %0d, predicted %0d",
                                      oldest.temp, duty_i, oldest.duty));
        end
      end
      duty_pending_o <= duty_due.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plfc_pkg::*;

  // indexes past the last register, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int RESET_PROBES[12] = '{-32768, 32767, -1, 24, 25, 26, 27, 34, 49, 59, 60, 61};
  localparam int UNSORTED_PROBES[5] = '{9, 10, 49, 55, 60};
  localparam int STEEP_PROBES[4] = '{-129, -128, 126, 127};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DUTY_W-1:0]        duty;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_TEMPS;
  logic [CFG_W-1:0]         cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int mismatches;
  int duty_pending;
  int curve_t[POINTS];

  always #5ns clk = ~clk;

  piecewise_linear_fan_curve dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .temperature_i(temperature),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .duty_o       (duty),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  fan_curve_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .temperature_i   (temperature),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .duty_i          (duty),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatches),
    .duty_pending_o  (duty_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("piecewise_linear_fan_curve verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void unpack_temps(input logic [CFG_W-1:0] r);
    logic signed [7:0] b;
    for (int i = 0; i < POINTS; i++) begin
      b = r[8*i +: 8];
      curve_t[i] = b;
    end
  endfunction

  task automatic send_temp(input int t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    temperature <= t[TEMP_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_duties;
    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_pending != 0) @(posedge clk);
  endtask

  task automatic load_curve(input logic [CFG_W-1:0] temps, input logic [CFG_W-1:0] duties);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [CFG_W-1:0]     val[3];
    idx[0] = REG_TEMPS;
    val[0] = temps;
    idx[1] = REG_DUTIES;
    val[1] = duties;
    idx[2] = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
    val[2] = CFG_W'({$urandom, $urandom});
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    unpack_temps(temps);
  endtask

  task automatic random_curve;
    int               t[POINTS];
    int               hold;
    logic [CFG_W-1:0] temps;
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < POINTS; i++) t[i] = int'($urandom_range(255)) - 128;
      for (int i = 1; i < POINTS; i++) begin
        for (int j = i; j > 0 && t[j-1] > t[j]; j--) begin
          hold   = t[j];
          t[j]   = t[j-1];
          t[j-1] = hold;
        end
      end
      for (int i = 0; i < POINTS; i++) temps[8*i +: 8] = t[i][7:0];
    end else begin
      // raw register, usually unsorted
      temps = CFG_W'({$urandom, $urandom});
    end
    load_curve(temps, CFG_W'({$urandom, $urandom}));
  endtask

  initial begin
    int lo;
    int hi;
    int r;
    int t;
    unpack_temps(TEMPS_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 46;

    // default curve: clamps at both ends, breakpoints and their neighbours
    foreach (RESET_PROBES[i]) send_temp(RESET_PROBES[i]);
    drain_duties();
    load_curve(48'h3CFB1E14320A, 48'h42B46303F011);
    foreach (UNSORTED_PROBES[i]) send_temp(UNSORTED_PROBES[i]);
    drain_duties();
    // full byte span with zero-width segments and full-scale swings
    load_curve(48'h7F7F00008080, 48'h00FF00FF00FF);
    foreach (STEEP_PROBES[i]) send_temp(STEEP_PROBES[i]);
    drain_duties();
    load_curve('1, '1);
    send_temp(-2);
    send_temp(0);
    drain_duties();
    load_curve('0, '0);
    send_temp(-1);
    send_temp(0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 46 : 0;
      recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 22 : 0;
      repeat (4) begin
        drain_duties();
        random_curve();
        lo = curve_t[0];
        hi = curve_t[0];
        foreach (curve_t[i]) begin
          if (curve_t[i] < lo) lo = curve_t[i];
          if (curve_t[i] > hi) hi = curve_t[i];
        end
        lo = lo - 6;
        hi = hi + 6;
        repeat (48) begin
          r = $urandom_range(99);
          if (r < 75) t = lo + int'($urandom_range(hi - lo));
          else if (r < 90) t = curve_t[$urandom_range(POINTS - 1)] + int'($urandom_range(2)) - 1;
          else t = int'($urandom_range(16'hFFFF));
          send_temp(t);
        end
      end
    end

    drain_duties();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("piecewise_linear_fan_curve verification clean");
    end else begin
      $display("piecewise_linear_fan_curve verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/plfc_pkg.sv
hdl/plfc_seg.sv
hdl/plfc_mul.sv
hdl/plfc_div_cell.sv
hdl/plfc_out.sv
hdl/piecewise_linear_fan_curve.sv
hdl/plfc_chk.sv
tb/sv/fan_curve_checker.sv
tb/sv/tb_top.sv
